FILE: sv/image_rotate_90_clockwise_macros.svh
// Assertion macros shared by the image rotator queue and back end.
`ifndef IMAGE_ROTATE_90_CLOCKWISE_MACROS_SVH
`define IMAGE_ROTATE_90_CLOCKWISE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IROT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IROT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IROT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/irot_pkg.sv
// Shared types and constants of the image rotator.
package irot_pkg;
    localparam int SIDE_BITS    = 5;
    localparam int POS_BITS     = 4;
    localparam int OUT_PIX_BITS = 8;
    localparam int Q_DEPTH      = 2;
    localparam logic [SIDE_BITS-1:0] SIDE_RESET = 5'd16;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic                fetch;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
        logic                ready;
    } t_meta;
endpackage

FILE: sv/irot_front.sv
// Front end: load and fetch counters, address remapping and request build.
module irot_front #(
    parameter int MAX_SIDE   = 16,
    parameter int PIXEL_BITS = 8,
    parameter int CW = $clog2(MAX_SIDE),
    parameter int AW = $clog2(MAX_SIDE * MAX_SIDE),
    parameter int SB = (PIXEL_BITS < 8) ? PIXEL_BITS : 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_write,
    input  logic [irot_pkg::SIDE_BITS-1:0] i_cfg_data,
    input  logic                          i_push,
    input  logic                          i_mode,
    input  logic [7:0]                    i_pixel_in,
    output irot_pkg::t_meta               o_meta,
    output logic [AW-1:0]                 o_addr,
    output logic [SB-1:0]                 o_data
);
    import irot_pkg::*;

    localparam logic [6:0] MaxSide = 7'(MAX_SIDE);
    localparam logic [6:0] ResetEff =
        ({2'b0, SIDE_RESET} > MaxSide) ? MaxSide : {2'b0, SIDE_RESET};
    localparam logic [CW-1:0] ResetM1 = CW'(ResetEff - 7'd1);

    logic [CW-1:0] r_m1, n_m1;
    logic [CW-1:0] r_ld_row, n_ld_row, r_ld_col, n_ld_col;
    logic [CW-1:0] r_rd_row, n_rd_row, r_rd_col, n_rd_col;
    logic          r_loaded, n_loaded;
    logic [6:0]    w_eff;
    logic [CW-1:0] w_src_row;
    logic [CW+POS_BITS-1:0] w_row_ext, w_col_ext;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_eff = 7'd1;
        end else if ({2'b0, i_cfg_data} > MaxSide) begin
            w_eff = MaxSide;
        end else begin
            w_eff = {2'b0, i_cfg_data};
        end
    end

    always_comb begin
        n_m1     = r_m1;
        n_ld_row = r_ld_row;
        n_ld_col = r_ld_col;
        n_rd_row = r_rd_row;
        n_rd_col = r_rd_col;
        n_loaded = r_loaded;
        if (i_cfg_write) begin
            n_m1     = CW'(w_eff - 7'd1);
            n_ld_row = '0;
            n_ld_col = '0;
            n_rd_row = '0;
            n_rd_col = '0;
            n_loaded = 1'b0;
        end else if (i_push) begin
            if (i_mode == MODE_LOAD) begin
                if (r_ld_col == r_m1) begin
                    n_ld_col = '0;
                    if (r_ld_row == r_m1) begin
                        n_ld_row = '0;
                        n_loaded = 1'b1;
                    end else begin
                        n_ld_row = r_ld_row + 1'b1;
                    end
                end else begin
                    n_ld_col = r_ld_col + 1'b1;
                end
            end else begin
                if (r_rd_col == r_m1) begin
                    n_rd_col = '0;
                    if (r_rd_row == r_m1) begin
                        n_rd_row = '0;
                    end else begin
                        n_rd_row = r_rd_row + 1'b1;
                    end
                end else begin
                    n_rd_col = r_rd_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1     <= ResetM1;
            r_ld_row <= '0;
            r_ld_col <= '0;
            r_rd_row <= '0;
            r_rd_col <= '0;
            r_loaded <= 1'b0;
        end else begin
            r_m1     <= n_m1;
            r_ld_row <= n_ld_row;
            r_ld_col <= n_ld_col;
            r_rd_row <= n_rd_row;
            r_rd_col <= n_rd_col;
            r_loaded <= n_loaded;
        end
    end

    // rotated (r, c) reads source (n-1-c, r)
    assign w_src_row = r_m1 - r_rd_col;
    assign w_row_ext = {{POS_BITS{1'b0}}, r_rd_row};
    assign w_col_ext = {{POS_BITS{1'b0}}, r_rd_col};

    always_comb begin
        o_meta = '0;
        if (i_mode == MODE_LOAD) begin
            o_addr = AW'(r_ld_row) * AW'(MAX_SIDE) + AW'(r_ld_col);
        end else begin
            o_meta.fetch = 1'b1;
            o_meta.row   = w_row_ext[POS_BITS-1:0];
            o_meta.col   = w_col_ext[POS_BITS-1:0];
            o_meta.last  = (r_rd_row == r_m1) && (r_rd_col == r_m1);
            o_meta.ready = r_loaded;
            o_addr = AW'(w_src_row) * AW'(MAX_SIDE) + AW'(r_rd_row);
        end
    end

    assign o_data = i_pixel_in[SB-1:0];
endmodule

FILE: sv/irot_queue.sv
// Two-entry request queue between front end and back end.
`include "image_rotate_90_clockwise_macros.svh"
module irot_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    import irot_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNTW'(Q_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    `IROT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(Q_DEPTH))
    `IROT_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `IROT_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
endmodule

FILE: sv/irot_back.sv
// Back end: frame store, write or remapped read, result register.
`include "image_rotate_90_clockwise_macros.svh"
module irot_back #(
    parameter int MAX_SIDE   = 16,
    parameter int PIXEL_BITS = 8,
    parameter int AW = $clog2(MAX_SIDE * MAX_SIDE),
    parameter int SB = (PIXEL_BITS < 8) ? PIXEL_BITS : 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  irot_pkg::t_meta i_q_meta,
    input  logic [AW-1:0]   i_q_addr,
    input  logic [SB-1:0]   i_q_data,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [irot_pkg::OUT_PIX_BITS-1:0] o_pixel_out,
    output logic [irot_pkg::POS_BITS-1:0]     o_out_row,
    output logic [irot_pkg::POS_BITS-1:0]     o_out_col,
    output logic            o_last_pixel,
    output logic            o_frame_ready
);
    import irot_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    logic [SB-1:0] r_store [DEPTH];
    logic [SB-1:0] r_pix;
    t_meta         r_meta;
    logic          r_out_valid, n_out_valid;
    logic          w_slot_free, w_pop_fetch, w_pop_load;
    logic [SB+OUT_PIX_BITS-1:0] w_pix_ext;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_valid && (!i_q_meta.fetch || w_slot_free);
    assign w_pop_fetch = o_pop && i_q_meta.fetch;
    assign w_pop_load  = o_pop && !i_q_meta.fetch;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_pop_fetch) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_load) begin
            r_store[i_q_addr] <= i_q_data;
        end
        if (w_pop_fetch) begin
            r_pix  <= r_store[i_q_addr];
            r_meta <= i_q_meta;
        end
    end

    assign w_pix_ext     = {{OUT_PIX_BITS{1'b0}}, r_pix};
    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = w_pix_ext[OUT_PIX_BITS-1:0];
    assign o_out_row     = r_meta.row;
    assign o_out_col     = r_meta.col;
    assign o_last_pixel  = r_meta.last;
    assign o_frame_ready = r_meta.ready;

    `IROT_ASSERT_SAME(a_pop_valid, i_clk, i_rst_n, o_pop, i_q_valid)
    `IROT_ASSERT_SAME(a_no_clobber, i_clk, i_rst_n, w_pop_fetch, !(r_out_valid && i_out_stall))
    `IROT_ASSERT_NEXT(a_drain, i_clk, i_rst_n, r_out_valid && !i_out_stall && !w_pop_fetch, !r_out_valid)
endmodule

FILE: sv/image_rotate_90_clockwise.sv
// Top level of the 90 degree clockwise image rotator.
//
// Input channel (i_in_valid / o_in_stall) carries requests: mode 0 loads
// i_pixel_in into the frame store in row-major order, mode 1 fetches the
// next pixel of the rotated image. Loads give no result; each fetch gives
// one result on the output channel (o_out_valid / i_out_stall) with the
// pixel, its row and column, a last-pixel flag and a frame-ready flag.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready)
// sets the side length; write it only while idle. It restarts both
// counters and clears frame-ready.
// Throughput: one request per cycle while o_in_stall is low, set by the
// single store port. An accepted fetch passes through the request queue
// and the registered store read before it reaches the output channel.
// A stalled result holds; loads keep draining behind it until a fetch
// heads the queue, and the input stalls once the two-entry queue fills.
// Reset: counters cleared, side length 16, queue and output empty. The
// frame store holds no reset value; fetch only entries already loaded.
module image_rotate_90_clockwise #(
    parameter int MAX_SIDE   = 16,
    parameter int PIXEL_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [irot_pkg::SIDE_BITS-1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [7:0] i_pixel_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_pixel_out,
    output logic [3:0] o_out_row,
    output logic [3:0] o_out_col,
    output logic       o_last_pixel,
    output logic       o_frame_ready
);
    import irot_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int SB = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
    localparam int QW = $bits(t_meta) + AW + SB;

    t_meta          w_f_meta, w_q_meta;
    logic [AW-1:0]  w_f_addr, w_q_addr;
    logic [SB-1:0]  w_f_data, w_q_data;
    logic           w_push, w_pop, w_q_valid, w_q_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_full;
    assign w_push      = i_in_valid && !w_q_full;

    irot_front #(
        .MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS), .CW(CW), .AW(AW), .SB(SB)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_write(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_push     (w_push),
        .i_mode     (i_mode),
        .i_pixel_in (i_pixel_in),
        .o_meta     (w_f_meta),
        .o_addr     (w_f_addr),
        .o_data     (w_f_data)
    );

    irot_queue #(.WIDTH(QW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_f_meta, w_f_addr, w_f_data}),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_full (w_q_full),
        .o_data ({w_q_meta, w_q_addr, w_q_data})
    );

    irot_back #(
        .MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS), .AW(AW), .SB(SB)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_meta     (w_q_meta),
        .i_q_addr     (w_q_addr),
        .i_q_data     (w_q_data),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_last_pixel (o_last_pixel),
        .o_frame_ready(o_frame_ready)
    );
endmodule

FILE: test/rotation_check.sv
// Checker that predicts the rotated pixels from the accepted requests and compares results.
module rotation_check
    import irot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [SIDE_BITS-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_mode,
    input  logic [7:0]           i_pixel_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [7:0]           i_pixel_out,
    input  logic [3:0]           i_out_row,
    input  logic [3:0]           i_out_col,
    input  logic                 i_last_pixel,
    input  logic                 i_frame_ready,
    output int                   o_pending,
    output int                   o_fail_count
);
    typedef struct packed {
        logic [7:0] pixel;
        logic [3:0] row;
        logic [3:0] col;
        logic       last;
        logic       ready;
    } t_rot_pixel;

    logic [7:0]           frame_mem [256];
    logic [3:0]           ld_row;
    logic [3:0]           ld_col;
    logic [3:0]           rd_row;
    logic [3:0]           rd_col;
    logic                 frame_done;
    logic [SIDE_BITS-1:0] side_reg;
    t_rot_pixel           rotated_pixels [$];
    int                   fails = 0;

    function automatic int active_side();
        if (side_reg == '0) begin
            return 1;
        end
        if (int'(side_reg) > 16) begin
            return 16;
        end
        return int'(side_reg);
    endfunction

    // Returns 1 when the position wraps back to the first pixel.
    function automatic bit step_position(inout logic [3:0] r, inout logic [3:0] c,
                                         input int n);
        if (int'(c) + 1 >= n) begin
            c = '0;
            if (int'(r) + 1 >= n) begin
                r = '0;
                return 1'b1;
            end
            r = r + 4'd1;
            return 1'b0;
        end
        c = c + 4'd1;
        return 1'b0;
    endfunction

    task automatic absorb_request(input logic mode, input logic [7:0] pix);
        int         n;
        t_rot_pixel item;
        logic [3:0] src_row;
        n = active_side();
        if (int'(ld_row) >= n || int'(ld_col) >= n) begin
            ld_row = '0;
            ld_col = '0;
        end
        if (int'(rd_row) >= n || int'(rd_col) >= n) begin
            rd_row = '0;
            rd_col = '0;
        end
        if (mode == MODE_LOAD) begin
            frame_mem[{ld_row, ld_col}] = pix;
            if (step_position(ld_row, ld_col, n)) begin
                frame_done = 1'b1;
            end
        end else begin
            src_row    = 4'(n - 1 - int'(rd_col));
            item.pixel = frame_mem[{src_row, rd_row}];
            item.row   = rd_row;
            item.col   = rd_col;
            item.last  = (int'(rd_row) == n - 1) && (int'(rd_col) == n - 1);
            item.ready = frame_done;
            rotated_pixels.push_back(item);
            void'(step_position(rd_row, rd_col, n));
        end
    endtask

    task automatic report_field(input string field, input logic [7:0] want_v,
                                input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rot_pixel want;
        if (!i_rst_n) begin
            ld_row     = '0;
            ld_col     = '0;
            rd_row     = '0;
            rd_col     = '0;
            frame_done = 1'b0;
            side_reg   = SIDE_RESET;
            rotated_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                side_reg   = i_cfg_data;
                ld_row     = '0;
                ld_col     = '0;
                rd_row     = '0;
                rd_col     = '0;
                frame_done = 1'b0;
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_request(i_mode, i_pixel_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (rotated_pixels.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual pixel %0d row %0d col %0d",
                             $time, i_pixel_out, i_out_row, i_out_col);
                    fails++;
                end else begin
                    want = rotated_pixels.pop_front();
                    report_field("pixel_out", want.pixel, i_pixel_out);
                    report_field("out_row", 8'(want.row), 8'(i_out_row));
                    report_field("out_col", 8'(want.col), 8'(i_out_col));
                    report_field("last_pixel", 8'(want.last), 8'(i_last_pixel));
                    report_field("frame_ready", 8'(want.ready), 8'(i_frame_ready));
                end
            end
        end
        o_pending    <= rotated_pixels.size();
        o_fail_count <= fails;
    end
endmodule

FILE: test/tb_image_rotate_90_clockwise.sv
// Top of the image rotator testbench: clock, reset, requests, receiver stalls and verdict.
module tb_image_rotate_90_clockwise;
    import irot_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [SIDE_BITS-1:0] i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_mode      = MODE_LOAD;
    logic [7:0]           i_pixel_in  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_pixel_out;
    logic [3:0]           o_out_row;
    logic [3:0]           o_out_col;
    logic                 o_last_pixel;
    logic                 o_frame_ready;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    int stall_tick  = 0;

    // Stimulus-side view of the store, used to keep every fetch on loaded entries.
    bit loaded_mask [256];
    int side_n = 16;
    int ld_r   = 0;
    int ld_c   = 0;
    int rd_r   = 0;
    int rd_c   = 0;

    bit holding    = 1'b0;
    int burst_left = 8;

    image_rotate_90_clockwise dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_last_pixel (o_last_pixel),
        .o_frame_ready(o_frame_ready)
    );

    rotation_check u_rotation_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_pixel_in   (i_pixel_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_pixel_out  (o_pixel_out),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_last_pixel (o_last_pixel),
        .i_frame_ready(o_frame_ready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[8:7])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 1) == 1);
            2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void next_pos(inout int r, inout int c);
        if (c + 1 >= side_n) begin
            c = 0;
            r = (r + 1 >= side_n) ? 0 : r + 1;
        end else begin
            c = c + 1;
        end
    endfunction

    task automatic send_request(input logic mode, input logic [7:0] pix);
        int gap;
        if (!holding) begin
            i_in_valid <= 1'b1;
        end
        i_mode     <= mode;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        holding = 1'b1;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                holding = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Turn a fetch into a load when it would read an entry never loaded.
    task automatic issue(input logic mode_req, input logic [7:0] pix);
        logic mode_use;
        mode_use = mode_req;
        if (mode_use == MODE_FETCH && !loaded_mask[(side_n - 1 - rd_c) * 16 + rd_r]) begin
            mode_use = MODE_LOAD;
        end
        if (mode_use == MODE_LOAD) begin
            loaded_mask[ld_r * 16 + ld_c] = 1'b1;
            next_pos(ld_r, ld_c);
        end else begin
            next_pos(rd_r, rd_c);
        end
        send_request(mode_use, pix);
    endtask

    task automatic quiesce();
        if (holding) begin
            i_in_valid <= 1'b0;
            holding = 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_side(input int v);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= SIDE_BITS'(v);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        side_n = (v == 0) ? 1 : ((v > 16) ? 16 : v);
        ld_r   = 0;
        ld_c   = 0;
        rd_r   = 0;
        rd_c   = 0;
    endtask

    task automatic run_frames(input int side_val, input int frames, input int extra);
        write_side(side_val);
        repeat (frames) begin
            repeat (side_n * side_n) begin
                if ($urandom_range(0, 9) == 0) begin
                    issue(MODE_FETCH, rand_pixel());
                end
                issue(MODE_LOAD, rand_pixel());
            end
            repeat (side_n * side_n) begin
                if ($urandom_range(0, 9) == 0) begin
                    issue(MODE_LOAD, rand_pixel());
                end
                issue(MODE_FETCH, rand_pixel());
            end
        end
        repeat (extra) issue(1'($urandom_range(0, 1)), rand_pixel());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // side zero runs as a single pixel
        write_side(0);
        issue(MODE_LOAD, 8'hFF);
        issue(MODE_FETCH, 8'h00);
        issue(MODE_LOAD, 8'h00);
        issue(MODE_FETCH, 8'hFF);

        // full two by two frame, then one fetch past the wrap
        write_side(2);
        issue(MODE_LOAD, 8'h01);
        issue(MODE_LOAD, 8'hFF);
        issue(MODE_LOAD, 8'h80);
        issue(MODE_LOAD, 8'h7E);
        repeat (5) issue(MODE_FETCH, 8'h00);

        // restart, then fetch from the old contents before the frame is complete
        write_side(2);
        issue(MODE_FETCH, 8'h00);
        issue(MODE_FETCH, 8'h00);
        issue(MODE_LOAD, 8'hA5);
        issue(MODE_LOAD, 8'h5A);
        issue(MODE_FETCH, 8'h00);
        issue(MODE_FETCH, 8'h00);

        run_frames(3, 2, 12);
        run_frames(1, 4, 6);

        // full-size frame, then the first rotated rows
        write_side(16);
        repeat (256) issue(MODE_LOAD, rand_pixel());
        repeat (24) issue(MODE_FETCH, rand_pixel());

        run_frames(31, 0, 24);
        run_frames(17, 0, 12);
        run_frames(5, 1, 8);
        run_frames(0, 3, 8);
        run_frames(2, 2, 12);
        run_frames($urandom_range(1, 4), 1, 4);

        quiesce();
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/irot_pkg.sv
sv/irot_front.sv
sv/irot_queue.sv
sv/irot_back.sv
sv/image_rotate_90_clockwise.sv
test/rotation_check.sv
test/tb_image_rotate_90_clockwise.sv
